// ===== rtl/plti_pkg.sv =====
// ----------------------------------------------------------------------------
// plti_pkg
// Breakpoint tables, widths and shared types of the table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

    localparam int TABLE_ROWS = 20;
    localparam int IDX_W      = 5;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int SPAN_W     = 24;
    localparam int MAG_W      = 32;
    localparam int PROD_W     = SPAN_W + MAG_W;
    localparam int QUOT_W     = 32;

    localparam logic [1:0] SEL_GRAV  = 2'd0;
    localparam logic [1:0] SEL_RHO   = 2'd1;
    localparam logic [1:0] SEL_SOUND = 2'd2;
    localparam logic [1:0] SEL_DRAG  = 2'd3;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        val;
    } t_bp;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [SPAN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    // altitude in meters to Q24.8
    function automatic logic signed [KEY_W-1:0] alt_key(input longint m);
        return KEY_W'(m * 256);
    endfunction

    // thousandths of mach to Q16.16, rounded half up
    function automatic logic signed [KEY_W-1:0] mach_key(input longint t);
        return KEY_W'((t * 65536 + 500) / 1000);
    endfunction

    function automatic logic [VAL_W-1:0] rq_milli(input longint n);
        return VAL_W'((n * 4194304 + 500) / 1000);
    endfunction

    function automatic logic [VAL_W-1:0] rq_e4(input longint n);
        return VAL_W'((n * 4194304 + 5000) / 10000);
    endfunction

    function automatic logic [VAL_W-1:0] rq_e7(input longint n);
        return VAL_W'((n * 4194304 + 5000000) / 10000000);
    endfunction

    function automatic logic [VAL_W-1:0] rq_unit(input longint n);
        return VAL_W'(n * 4194304);
    endfunction

    function automatic logic [IDX_W-1:0] row_count(input logic [1:0] sel);
        logic [IDX_W-1:0] n;
        n = (sel == SEL_DRAG) ? IDX_W'(18) : IDX_W'(20);
        return n;
    endfunction

    function automatic logic signed [KEY_W-1:0] alt_row(input logic [IDX_W-1:0] idx);
        logic signed [KEY_W-1:0] k;
        case (idx)
            5'd0:  k = alt_key(0);
            5'd1:  k = alt_key(1000);
            5'd2:  k = alt_key(2000);
            5'd3:  k = alt_key(3000);
            5'd4:  k = alt_key(4000);
            5'd5:  k = alt_key(5000);
            5'd6:  k = alt_key(6000);
            5'd7:  k = alt_key(7000);
            5'd8:  k = alt_key(8000);
            5'd9:  k = alt_key(9000);
            5'd10: k = alt_key(10000);
            5'd11: k = alt_key(15000);
            5'd12: k = alt_key(20000);
            5'd13: k = alt_key(25000);
            5'd14: k = alt_key(30000);
            5'd15: k = alt_key(40000);
            5'd16: k = alt_key(50000);
            5'd17: k = alt_key(60000);
            5'd18: k = alt_key(70000);
            5'd19: k = alt_key(80000);
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic signed [KEY_W-1:0] mach_row(input logic [IDX_W-1:0] idx);
        logic signed [KEY_W-1:0] k;
        case (idx)
            5'd0:  k = mach_key(0);
            5'd1:  k = mach_key(100);
            5'd2:  k = mach_key(300);
            5'd3:  k = mach_key(500);
            5'd4:  k = mach_key(700);
            5'd5:  k = mach_key(890);
            5'd6:  k = mach_key(920);
            5'd7:  k = mach_key(960);
            5'd8:  k = mach_key(980);
            5'd9:  k = mach_key(1000);
            5'd10: k = mach_key(1020);
            5'd11: k = mach_key(1060);
            5'd12: k = mach_key(1240);
            5'd13: k = mach_key(1530);
            5'd14: k = mach_key(1990);
            5'd15: k = mach_key(2870);
            5'd16: k = mach_key(2890);
            5'd17: k = mach_key(5000);
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] grav_val(input logic [IDX_W-1:0] idx);
        logic [VAL_W-1:0] v;
        case (idx)
            5'd0:  v = rq_milli(9807);
            5'd1:  v = rq_milli(9804);
            5'd2:  v = rq_milli(9801);
            5'd3:  v = rq_milli(9797);
            5'd4:  v = rq_milli(9794);
            5'd5:  v = rq_milli(9791);
            5'd6:  v = rq_milli(9788);
            5'd7:  v = rq_milli(9785);
            5'd8:  v = rq_milli(9782);
            5'd9:  v = rq_milli(9779);
            5'd10: v = rq_milli(9776);
            5'd11: v = rq_milli(9761);
            5'd12: v = rq_milli(9745);
            5'd13: v = rq_milli(9730);
            5'd14: v = rq_milli(9715);
            5'd15: v = rq_milli(9684);
            5'd16: v = rq_milli(9654);
            5'd17: v = rq_milli(9624);
            5'd18: v = rq_milli(9594);
            5'd19: v = rq_milli(9564);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] rho_val(input logic [IDX_W-1:0] idx);
        logic [VAL_W-1:0] v;
        case (idx)
            5'd0:  v = rq_e7(12250000);
            5'd1:  v = rq_e7(11120000);
            5'd2:  v = rq_e7(10070000);
            5'd3:  v = rq_e7(9093000);
            5'd4:  v = rq_e7(8194000);
            5'd5:  v = rq_e7(7364000);
            5'd6:  v = rq_e7(6601000);
            5'd7:  v = rq_e7(5900000);
            5'd8:  v = rq_e7(5258000);
            5'd9:  v = rq_e7(4671000);
            5'd10: v = rq_e7(4135000);
            5'd11: v = rq_e7(1948000);
            5'd12: v = rq_e7(889100);
            5'd13: v = rq_e7(400800);
            5'd14: v = rq_e7(184100);
            5'd15: v = rq_e7(39960);
            5'd16: v = rq_e7(10270);
            5'd17: v = rq_e7(3097);
            5'd18: v = rq_e7(828);
            5'd19: v = rq_e7(185);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] sound_val(input logic [IDX_W-1:0] idx);
        logic [VAL_W-1:0] v;
        case (idx)
            5'd0:  v = rq_unit(340);
            5'd1:  v = rq_unit(336);
            5'd2:  v = rq_unit(332);
            5'd3:  v = rq_unit(328);
            5'd4:  v = rq_unit(324);
            5'd5:  v = rq_unit(320);
            5'd6:  v = rq_unit(316);
            5'd7:  v = rq_unit(312);
            5'd8:  v = rq_unit(308);
            5'd9:  v = rq_unit(303);
            5'd10: v = rq_unit(299);
            5'd11: v = rq_unit(295);
            5'd12: v = rq_unit(295);
            5'd13: v = rq_unit(295);
            5'd14: v = rq_unit(305);
            5'd15: v = rq_unit(324);
            5'd16: v = rq_unit(337);
            5'd17: v = rq_unit(319);
            5'd18: v = rq_unit(289);
            5'd19: v = rq_unit(269);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] drag_val(input logic [IDX_W-1:0] idx);
        logic [VAL_W-1:0] v;
        case (idx)
            5'd0:  v = rq_e4(0);
            5'd1:  v = rq_e4(543);
            5'd2:  v = rq_e4(1629);
            5'd3:  v = rq_e4(1659);
            5'd4:  v = rq_e4(2031);
            5'd5:  v = rq_e4(2597);
            5'd6:  v = rq_e4(3010);
            5'd7:  v = rq_e4(3287);
            5'd8:  v = rq_e4(4002);
            5'd9:  v = rq_e4(4258);
            5'd10: v = rq_e4(4335);
            5'd11: v = rq_e4(4483);
            5'd12: v = rq_e4(4064);
            5'd13: v = rq_e4(3663);
            5'd14: v = rq_e4(2897);
            5'd15: v = rq_e4(2297);
            5'd16: v = rq_e4(2306);
            5'd17: v = rq_e4(2656);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_bp rom_read(input logic [1:0] sel, input logic [IDX_W-1:0] idx);
        t_bp bp;
        case (sel)
            SEL_GRAV:  bp = '{key: alt_row(idx), val: grav_val(idx)};
            SEL_RHO:   bp = '{key: alt_row(idx), val: rho_val(idx)};
            SEL_SOUND: bp = '{key: alt_row(idx), val: sound_val(idx)};
            SEL_DRAG:  bp = '{key: mach_row(idx), val: drag_val(idx)};
            default:   bp = '0;
        endcase
        return bp;
    endfunction

endpackage

// ===== rtl/piecewise_linear_table_interpolator.sv =====
// When the argument clamps to a table end, the S_EDGE check registers the result to o_valid;
// otherwise the segment scan compares one breakpoint per cycle, then the S_MUL multiply,
// S_DLOAD and the 32-step divider follow. busy falls in the o_valid cycle, so the next
// start is taken at the edge ending it.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops o_valid.
// o_valid is a single-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Clamped piecewise-linear lookup in four constant breakpoint tables.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator #(
    parameter int MAX_ENTRIES = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic signed [31:0] i_argument,
    output logic        o_valid,
    output logic [31:0] o_value
);

    localparam int IDX_W  = plti_pkg::IDX_W;
    localparam int SPAN_W = plti_pkg::SPAN_W;
    localparam int MAG_W  = plti_pkg::MAG_W;
    localparam int PROD_W = plti_pkg::PROD_W;
    localparam int VAL_W  = plti_pkg::VAL_W;
    localparam int KEY_W  = plti_pkg::KEY_W;
    localparam int CAP    = (MAX_ENTRIES < plti_pkg::TABLE_ROWS) ? MAX_ENTRIES
                                                                 : plti_pkg::TABLE_ROWS;
    localparam logic [IDX_W-1:0] CAP_L = IDX_W'(CAP);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EDGE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DLOAD = 3'd4;
    localparam logic [2:0] S_DWAIT = 3'd5;

    logic [2:0]              r_state, n_state;
    logic                    r_valid, n_valid;
    logic [1:0]              r_sel, n_sel;
    logic signed [KEY_W-1:0] r_x, n_x;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [IDX_W-1:0]        r_last, n_last;
    logic [SPAN_W-1:0]       r_dx, n_dx;
    logic [SPAN_W-1:0]       r_span, n_span;
    logic [MAG_W-1:0]        r_drmag, n_drmag;
    logic                    r_neg, n_neg;
    logic [VAL_W-1:0]        r_base, n_base;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic [VAL_W-1:0]        r_value, n_value;

    logic [IDX_W-1:0]        w_cnt;
    logic [IDX_W-1:0]        w_idx_a, w_idx_b;
    plti_pkg::t_bp           w_bp_a, w_bp_b;
    logic signed [KEY_W:0]   w_dx_full, w_span_full;
    plti_pkg::t_div_req      w_div_req;
    plti_pkg::t_div_rsp      w_div_rsp;

    // two constant-table reads: segment ends while scanning, table ends on the first pass
    assign w_idx_a = (r_state == S_EDGE) ? '0 : r_idx;
    assign w_idx_b = (r_state == S_EDGE) ? r_last : IDX_W'(r_idx + 1'b1);
    assign w_bp_a  = plti_pkg::rom_read(r_sel, w_idx_a);
    assign w_bp_b  = plti_pkg::rom_read(r_sel, w_idx_b);

    assign w_dx_full   = (KEY_W+1)'(r_x) - (KEY_W+1)'(w_bp_a.key);
    assign w_span_full = (KEY_W+1)'(w_bp_b.key) - (KEY_W+1)'(w_bp_a.key);

    always_comb begin
        w_cnt = plti_pkg::row_count(i_command);
        if (w_cnt > CAP_L) begin
            w_cnt = CAP_L;
        end
    end

    assign w_div_req.start    = (r_state == S_DLOAD);
    assign w_div_req.dividend = r_prod + PROD_W'(r_span >> 1);
    assign w_div_req.divisor  = r_span;

    plti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_sel   = r_sel;
        n_x     = r_x;
        n_idx   = r_idx;
        n_last  = r_last;
        n_dx    = r_dx;
        n_span  = r_span;
        n_drmag = r_drmag;
        n_neg   = r_neg;
        n_base  = r_base;
        n_prod  = r_prod;
        n_value = r_value;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_sel   = i_command;
                    n_x     = i_argument;
                    n_last  = IDX_W'(w_cnt - 1'b1);
                    n_idx   = '0;
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (r_x <= w_bp_a.key) begin
                    n_value = w_bp_a.val;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_x >= w_bp_b.key) begin
                    n_value = w_bp_b.val;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // earlier breakpoints are all below x, so the first upper end >= x brackets it
                if (r_x <= w_bp_b.key) begin
                    n_dx    = w_dx_full[SPAN_W-1:0];
                    n_span  = w_span_full[SPAN_W-1:0];
                    n_neg   = (w_bp_b.val < w_bp_a.val);
                    n_drmag = (w_bp_b.val < w_bp_a.val) ? (w_bp_a.val - w_bp_b.val)
                                                        : (w_bp_b.val - w_bp_a.val);
                    n_base  = w_bp_a.val;
                    n_state = S_MUL;
                end else begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_dx) * PROD_W'(r_drmag);
                n_state = S_DLOAD;
            end
            S_DLOAD: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_rsp.done) begin
                    n_value = r_neg ? (r_base - w_div_rsp.quot) : (r_base + w_div_rsp.quot);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel   <= n_sel;
        r_x     <= n_x;
        r_idx   <= n_idx;
        r_last  <= n_last;
        r_dx    <= n_dx;
        r_span  <= n_span;
        r_drmag <= n_drmag;
        r_neg   <= n_neg;
        r_base  <= n_base;
        r_prod  <= n_prod;
        r_value <= n_value;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

// ===== rtl/plti_div.sv =====
// ----------------------------------------------------------------------------
// plti_div
// Restoring divider, one quotient bit per cycle, for the segment slope step.
// ----------------------------------------------------------------------------
module plti_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plti_pkg::t_div_req  i_req,
    output plti_pkg::t_div_rsp  o_rsp
);

    localparam int SPAN_W = plti_pkg::SPAN_W;
    localparam int QUOT_W = plti_pkg::QUOT_W;
    localparam int PROD_W = plti_pkg::PROD_W;
    localparam int CNT_W  = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SPAN_W-1:0] r_rem;
    logic [SPAN_W-1:0] r_dvs;
    logic [QUOT_W-1:0] r_low;

    logic [SPAN_W:0]   w_shift;
    logic [SPAN_W:0]   w_diff;
    logic              w_ge;

    // remainder stays below the divisor, so the shifted value fits one extra bit
    assign w_shift = {r_rem, r_low[QUOT_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_LAST) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // the dividend is below divisor * 2^QUOT_W, so its upper part seeds the remainder
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[PROD_W-1:QUOT_W];
            r_low <= i_req.dividend[QUOT_W-1:0];
            r_dvs <= i_req.divisor;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[SPAN_W-1:0] : w_shift[SPAN_W-1:0];
            r_low <= {r_low[QUOT_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_low;

endmodule

// ===== rtl/plti_chk.sv =====
// ----------------------------------------------------------------------------
// plti_chk
// Port-level checks on transaction ordering of the table interpolator.
// ----------------------------------------------------------------------------
module plti_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_command,
    input logic [31:0] i_argument,
    input logic        o_valid,
    input logic [31:0] o_value
);

    // an accepted start always raises busy in the cycle after it
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted start");

    // a result is only shown once work has finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe without a finished transaction");

    // every end of work delivers exactly one result
    a_fell_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("transaction finished without a result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_known_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_value, i_command[0] | 1'b1, i_argument[0] | 1'b1}))
        else $error("result value unknown");

endmodule

bind piecewise_linear_table_interpolator plti_chk u_plti_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_command  (i_command),
    .i_argument (i_argument),
    .o_valid    (o_valid),
    .o_value    (o_value)
);
